>>> src/ppm_pkg.sv
// Shared constants and types for the PPM frame generator.
`timescale 1ns / 1ps

package ppm_pkg;

    // Channel and timing geometry
    localparam int MAX_CH     = 8;
    localparam int CH_BITS    = (MAX_CH > 1) ? $clog2(MAX_CH) : 1;
    localparam int SLOT_BITS  = 4;
    localparam int TIME_BITS  = 16;
    localparam int SUM_BITS   = TIME_BITS + CH_BITS;
    localparam int ADDR_BITS  = CH_BITS + 1;
    localparam int MEM_DEPTH  = 2 * MAX_CH;

    // Field widths of the register and item ports
    localparam int GAP_BITS   = 10;
    localparam int FL_BITS    = 16;
    localparam int CNT_BITS   = 4;
    localparam int CIDX_BITS  = 2;
    localparam int CDATA_BITS = 16;
    localparam int WIDTH_BITS = 16;
    localparam int INDEX_BITS = 3;

    // Reset values and codes
    localparam logic [GAP_BITS-1:0]   RESET_GAP   = GAP_BITS'(300);
    localparam logic [FL_BITS-1:0]    RESET_FL    = FL_BITS'(20000);
    localparam logic [CNT_BITS-1:0]   RESET_CNT   = CNT_BITS'(6);
    localparam logic [TIME_BITS-1:0]  RESET_WIDTH = TIME_BITS'(1000);
    localparam logic [TIME_BITS-1:0]  TIME_MAX    = {TIME_BITS{1'b1}};
    localparam logic [SLOT_BITS-1:0]  SYNC_CODE   = SLOT_BITS'(MAX_CH);

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SUM_BITS-1:0]  sum_t;
    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [CIDX_BITS-1:0] {
        CFG_GAP       = 2'd0,
        CFG_FRAME_LEN = 2'd1,
        CFG_CHAN_CNT  = 2'd2
    } cfg_idx_t;

endpackage

>>> src/ppm_frame_generator_core.sv
// PPM frame generator: tick-driven slot sequencer over a banked width memory.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): each transaction is either a one
//   microsecond tick (cmd = tick) or a pending width write (cmd = write).
//   Output channel (out_valid / out_stall): exactly one result transaction
//   per input transaction, in order: pin level, current slot, frame start.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   gap, frame length or channel count while no transaction is in flight.
//   Output: a result is registered and presented in the cycle after its input
//   is accepted. Throughput: one input transaction per cycle unless the
//   output stalls. The slot width for the next tick is prefetched from the
//   width memory at every edge, so the registered read never stalls the tick
//   path; a write's effect on the frame sum is delayed and forwarded.
//   Stall: while the output register holds an untaken result and out_stall
//   is high, in_stall is high; otherwise a new input is taken every cycle.
//   Reset: all widths read as 1000 (per-entry valid bits, no clearing pass),
//   registers return to gap 300, frame 20000, 6 channels; the first tick
//   starts a frame.
module ppm_frame_generator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // input item channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [ppm_pkg::INDEX_BITS-1:0]    channel_index,
    input  logic [ppm_pkg::WIDTH_BITS-1:0]    width_us,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              pin_level,
    output logic [ppm_pkg::SLOT_BITS-1:0]     slot_now,
    output logic                              frame_start,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppm_pkg::CIDX_BITS-1:0]     cfg_index,
    input  logic [ppm_pkg::CDATA_BITS-1:0]    cfg_data
);

    // Width memory: entry {bank, channel}; no reset on the array
    ppm_pkg::time_t mem [ppm_pkg::MEM_DEPTH];

    // Config registers
    logic [ppm_pkg::GAP_BITS-1:0] gap_reg;
    logic [ppm_pkg::FL_BITS-1:0]  fl_reg;
    logic [ppm_pkg::CNT_BITS-1:0] cnt_reg;

    // Slot sequencer state
    ppm_pkg::slot_t slot_reg, slot_next;
    logic           marker_reg, marker_next;
    ppm_pkg::time_t pc_reg, pc_next;
    logic           pin_reg, pin_next;

    // Bank pointers: latest pending and active bank per channel
    logic [ppm_pkg::MAX_CH-1:0]    lat_reg, lat_next;
    logic [ppm_pkg::MAX_CH-1:0]    act_reg, act_next;
    logic [ppm_pkg::MEM_DEPTH-1:0] vld_reg;

    // Prefix sums of pending and active widths (entry k = channels below k)
    ppm_pkg::sum_t pend_pre_reg [ppm_pkg::MAX_CH+1];
    ppm_pkg::sum_t pend_pre_next[ppm_pkg::MAX_CH+1];
    ppm_pkg::sum_t act_pre_reg  [ppm_pkg::MAX_CH+1];

    // Prefetched width of the current slot
    ppm_pkg::time_t mem_rd_reg;
    ppm_pkg::time_t fwd_data_reg;
    logic           fwd_reg;
    logic           rdv_reg;

    // In-flight width write, held here until it is applied to the pending sums
    logic                            dl_pend_reg;
    logic [ppm_pkg::CH_BITS-1:0]     dl_ch_reg;
    ppm_pkg::time_t                  dl_new_reg;
    ppm_pkg::time_t                  old_rd_reg;
    logic                            dl_oldv_reg;

    // Output register
    logic           out_valid_reg;
    logic           out_pin_reg;
    ppm_pkg::slot_t out_slot_reg;
    logic           out_fs_reg;

    // Combinational helpers
    logic                           in_acc, tick_acc, wr_acc, cfg_acc;
    logic [ppm_pkg::CH_BITS-1:0]    wr_ch;
    logic [ppm_pkg::ADDR_BITS-1:0]  wr_addr, old_addr, rd_addr;
    logic                           fs_next;
    ppm_pkg::slot_t                 chan_n;
    logic                           in_sync;
    logic                           fs_now;
    ppm_pkg::time_t                 cur_w;
    ppm_pkg::time_t                 gap_ext;
    ppm_pkg::time_t                 mark_len;
    ppm_pkg::time_t                 chan_low;
    ppm_pkg::time_t                 sync_low;
    ppm_pkg::time_t                 low_len;
    logic [ppm_pkg::SUM_BITS:0]     sync_sum;
    logic [ppm_pkg::SUM_BITS:0]     fl_ext;
    ppm_pkg::time_t                 pc_inc;
    ppm_pkg::slot_t                 slot_adv;
    ppm_pkg::time_t                 dl_old;
    ppm_pkg::sum_t                  delta;
    ppm_pkg::slot_t                 code_now;

    // Handshakes
    assign in_stall  = out_valid_reg && out_stall;
    assign in_acc    = in_valid && !in_stall;
    assign tick_acc  = in_acc && (ppm_pkg::cmd_t'(cmd) == ppm_pkg::CMD_TICK);
    assign wr_acc    = in_acc && (ppm_pkg::cmd_t'(cmd) == ppm_pkg::CMD_WRITE);
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // Slot decode and phase lengths
    always_comb
    begin
        if (cnt_reg > ppm_pkg::CNT_BITS'(ppm_pkg::MAX_CH))
            chan_n = ppm_pkg::slot_t'(ppm_pkg::MAX_CH);
        else
            chan_n = ppm_pkg::slot_t'(cnt_reg);
        in_sync  = slot_reg >= chan_n;
        code_now = in_sync ? ppm_pkg::SYNC_CODE : slot_reg;
        fs_now   = (slot_reg == '0) && marker_reg && (pc_reg == '0);

        cur_w    = fwd_reg ? fwd_data_reg
                           : (rdv_reg ? mem_rd_reg : ppm_pkg::RESET_WIDTH);
        gap_ext  = ppm_pkg::time_t'(gap_reg);
        mark_len = (gap_reg == '0) ? ppm_pkg::time_t'(1) : gap_ext;
        chan_low = (cur_w > gap_ext) ? (cur_w - gap_ext) : '0;

        sync_sum = {1'b0, act_pre_reg[chan_n]} + (ppm_pkg::SUM_BITS+1)'(gap_reg);
        fl_ext   = (ppm_pkg::SUM_BITS+1)'(fl_reg);
        sync_low = (fl_ext > sync_sum) ? ppm_pkg::time_t'(fl_ext - sync_sum) : '0;
        low_len  = in_sync ? sync_low : chan_low;

        pc_inc   = (pc_reg == ppm_pkg::TIME_MAX) ? pc_reg : pc_reg + 1'b1;
        slot_adv = in_sync ? '0 : slot_reg + 1'b1;
    end

    // Advance the slot sequencer on a tick
    always_comb
    begin
        slot_next   = slot_reg;
        marker_next = marker_reg;
        pc_next     = pc_reg;
        pin_next    = pin_reg;
        if (tick_acc)
        begin
            pin_next = marker_reg;
            pc_next  = pc_inc;
            if (marker_reg)
            begin
                if (pc_inc >= mark_len)
                begin
                    marker_next = 1'b0;
                    pc_next     = '0;
                    if (low_len == '0)
                    begin
                        slot_next   = slot_adv;
                        marker_next = 1'b1;
                    end
                end
            end
            else if (pc_inc >= low_len)
            begin
                slot_next   = slot_adv;
                marker_next = 1'b1;
                pc_next     = '0;
            end
        end
    end

    // Bank bookkeeping: writes go to the bank that is not active
    always_comb
    begin
        wr_ch    = channel_index[ppm_pkg::CH_BITS-1:0];
        wr_addr  = {~act_reg[wr_ch], wr_ch};
        old_addr = {lat_reg[wr_ch], wr_ch};
        lat_next = lat_reg;
        act_next = act_reg;
        if (wr_acc)
            lat_next[wr_ch] = ~act_reg[wr_ch];
        if (tick_acc && fs_now)
            act_next = lat_reg;
    end

    // Prefetch address: pending bank when the next tick starts a frame
    always_comb
    begin
        fs_next = (slot_next == '0) && marker_next && (pc_next == '0);
        rd_addr = {fs_next ? lat_next[slot_next[ppm_pkg::CH_BITS-1:0]]
                           : act_next[slot_next[ppm_pkg::CH_BITS-1:0]],
                   slot_next[ppm_pkg::CH_BITS-1:0]};
    end

    // Apply the in-flight write to the pending prefix sums
    always_comb
    begin
        dl_old = dl_oldv_reg ? old_rd_reg : ppm_pkg::RESET_WIDTH;
        delta  = ppm_pkg::sum_t'(dl_new_reg) - ppm_pkg::sum_t'(dl_old);
        for (int k = 0; k <= ppm_pkg::MAX_CH; k++)
        begin
            if (dl_pend_reg && (int'(dl_ch_reg) < k))
                pend_pre_next[k] = pend_pre_reg[k] + delta;
            else
                pend_pre_next[k] = pend_pre_reg[k];
        end
    end

    // Width memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_acc)
            mem[wr_addr] <= width_us;
        mem_rd_reg   <= mem[rd_addr];
        old_rd_reg   <= mem[old_addr];
        fwd_data_reg <= width_us;
        dl_ch_reg    <= wr_ch;
        dl_new_reg   <= width_us;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= ppm_pkg::RESET_GAP;
            fl_reg        <= ppm_pkg::RESET_FL;
            cnt_reg       <= ppm_pkg::RESET_CNT;
            slot_reg      <= '0;
            marker_reg    <= 1'b1;
            pc_reg        <= '0;
            pin_reg       <= 1'b0;
            lat_reg       <= '0;
            act_reg       <= '0;
            vld_reg       <= '0;
            fwd_reg       <= 1'b0;
            rdv_reg       <= 1'b0;
            dl_pend_reg   <= 1'b0;
            dl_oldv_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= ppm_pkg::MAX_CH; k++)
            begin
                pend_pre_reg[k] <= ppm_pkg::sum_t'(k * int'(ppm_pkg::RESET_WIDTH));
                act_pre_reg[k]  <= ppm_pkg::sum_t'(k * int'(ppm_pkg::RESET_WIDTH));
            end
        end
        else
        begin
            // config writes
            if (cfg_acc)
            begin
                unique case (ppm_pkg::cfg_idx_t'(cfg_index))
                    ppm_pkg::CFG_GAP:       gap_reg <= cfg_data[ppm_pkg::GAP_BITS-1:0];
                    ppm_pkg::CFG_FRAME_LEN: fl_reg  <= cfg_data[ppm_pkg::FL_BITS-1:0];
                    ppm_pkg::CFG_CHAN_CNT:  cnt_reg <= cfg_data[ppm_pkg::CNT_BITS-1:0];
                    default: ;
                endcase
            end

            slot_reg   <= slot_next;
            marker_reg <= marker_next;
            pc_reg     <= pc_next;
            pin_reg    <= pin_next;
            lat_reg    <= lat_next;
            act_reg    <= act_next;
            if (wr_acc)
                vld_reg[wr_addr] <= 1'b1;

            // prefetch: forward a same-edge write into the read register
            fwd_reg <= wr_acc && (wr_addr == rd_addr);
            rdv_reg <= vld_reg[rd_addr];

            // track the write whose sum update lands next cycle
            dl_pend_reg <= wr_acc;
            dl_oldv_reg <= vld_reg[old_addr];

            pend_pre_reg <= pend_pre_next;
            if (tick_acc && fs_now)
                act_pre_reg <= pend_pre_next;

            // output register
            if (in_acc)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_pin_reg  <= wr_acc ? pin_reg : marker_reg;
            out_slot_reg <= code_now;
            out_fs_reg   <= tick_acc && fs_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pin_level   = out_pin_reg;
    assign slot_now    = out_slot_reg;
    assign frame_start = out_fs_reg;

    // Checks
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= ppm_pkg::slot_t'(ppm_pkg::MAX_CH))
        else $error("slot index beyond sync slot");

    a_fs_pin_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start |-> pin_level)
        else $error("frame start without marker level");

    a_fs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start |-> (slot_now == '0) || (slot_now == ppm_pkg::SYNC_CODE))
        else $error("frame start outside first slot");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    a_prefix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        act_pre_reg[0] == '0 && pend_pre_reg[0] == '0)
        else $error("empty prefix sum is not zero");

endmodule
